// ----- design/seau_pkg.sv -----
// shared types, constants and codes of the silhouette edge accumulator
package seau_pkg;

  localparam int NVTX    = 1024;
  localparam int EPV     = 32;
  localparam int VTX_W   = $clog2(NVTX);
  localparam int K_W     = $clog2(EPV);
  localparam int LEN_W   = $clog2(EPV + 1);
  localparam int CNT_W   = 8;
  localparam int ENT_W   = VTX_W + CNT_W;
  localparam int EDGE_AW = VTX_W + K_W;
  localparam int FAR_W   = 11;
  localparam int CAP_W   = 14;
  localparam int AVAIL_W = 12;
  localparam int MAG_W   = CNT_W + 1;
  localparam int COPY_W  = 8;
  localparam int PROD_W  = 2 * CAP_W;
  // floor(x / 6) for x below 2^14 is (x * 10923) >> 16
  localparam int RECIP   = 10923;
  localparam int RECIP_SH = 16;
  localparam int QUAD    = 6;
  localparam int CFG_W   = CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8192);

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_START = 2'd2,
    OP_EMIT  = 2'd3
  } op_t;

  typedef enum logic {
    CFG_VCOUNT = 1'b0,
    CFG_CAP    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [VTX_W-1:0] vertex_a;
    logic [VTX_W-1:0] vertex_b;
  } item_t;

  typedef struct packed {
    logic              valid_res;
    logic [VTX_W-1:0]  near_start;
    logic [VTX_W-1:0]  near_end;
    logic [FAR_W-1:0]  far_start;
    logic [FAR_W-1:0]  far_end;
    logic [COPY_W-1:0] copies;
    logic              exhausted;
    logic              last;
  } result_t;

  typedef struct packed {
    logic              restart;
    logic              load_prod;
    logic              load_avail;
    logic              charge;
    logic [COPY_W-1:0] copies;
  } bud_cmd_t;

endpackage

// ----- design/seau_ram.sv -----
// generic simple dual port ram with registered read
module seau_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/seau_budget.sv -----
// index budget: index counter and remaining whole quads
module seau_budget (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [seau_pkg::CAP_W-1:0] cap,
  input  seau_pkg::bud_cmd_t       cmd,
  output logic [seau_pkg::AVAIL_W-1:0] avail
);
  import seau_pkg::*;

  logic [CAP_W-1:0]  index_counter;
  logic [PROD_W-1:0] prod;
  logic [CAP_W:0]    diff;
  logic [CAP_W-1:0]  charge_amt;

  assign diff = {1'b0, cap} - {1'b0, index_counter};
  // six indices per quad
  assign charge_amt = (CAP_W'(cmd.copies) << 2) + (CAP_W'(cmd.copies) << 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      index_counter <= '0;
      avail <= '0;
    end else begin
      if (cmd.restart) begin
        index_counter <= '0;
      end
      if (cmd.load_avail) begin
        avail <= AVAIL_W'(prod >> RECIP_SH);
      end
      if (cmd.charge) begin
        avail <= avail - AVAIL_W'(cmd.copies);
        index_counter <= index_counter + charge_amt;
      end
    end
  end

  // room left divided by six, via reciprocal product
  always_ff @(posedge clk) begin
    if (cmd.load_prod) begin
      if (diff[CAP_W]) begin
        prod <= '0;
      end else begin
        prod <= PROD_W'(diff[CAP_W-1:0]) * PROD_W'(RECIP);
      end
    end
  end

endmodule

// ----- design/silhouette_edge_accumulator_unit.sv -----
// top level: list walker around the edge store and list length memories
// add edge: length read, then one ram read and compare per entry until a match or the list end
// emit list: length read, budget load, then an entry walk that output stall can hold
// one transaction at a time; results leave through an output register
// after reset a pass over all 1024 vertices zeroes the list lengths, no item is taken then
// synchronous active high reset clears control state and the configuration registers to defaults
module silhouette_edge_accumulator_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  seau_pkg::item_t            item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output seau_pkg::result_t          result,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [seau_pkg::CFG_W-1:0] cfg_data
);
  import seau_pkg::*;

  typedef enum logic [11:0] {
    S_INIT = 12'b0000_0000_0001,
    S_IDLE = 12'b0000_0000_0010,
    S_MARK = 12'b0000_0000_0100,
    A_LEN  = 12'b0000_0000_1000,
    A_LENW = 12'b0000_0001_0000,
    A_RD   = 12'b0000_0010_0000,
    A_EV   = 12'b0000_0100_0000,
    E_LEN  = 12'b0000_1000_0000,
    E_LENW = 12'b0001_0000_0000,
    E_RD   = 12'b0010_0000_0000,
    E_EV   = 12'b0100_0000_0000,
    E_FIN  = 12'b1000_0000_0000
  } state_t;

  state_t state;
  logic [FAR_W-1:0] vertex_count;
  logic [CAP_W-1:0] index_capacity;
  logic budget_exhausted;
  logic [VTX_W-1:0] init_ptr;
  logic [VTX_W-1:0] lo;
  logic [VTX_W-1:0] hi;
  logic neg_dir;
  logic [LEN_W-1:0] n;
  logic [LEN_W-1:0] k;
  logic pend_valid;
  result_t pend;

  logic len_we, len_re, edge_we, edge_re;
  logic [VTX_W-1:0] len_waddr;
  logic [LEN_W-1:0] len_wdata, len_rdata;
  logic [ENT_W-1:0] edge_wdata, edge_rdata;
  logic [EDGE_AW-1:0] edge_addr;
  bud_cmd_t bcmd;
  logic [AVAIL_W-1:0] avail;

  logic accept, out_free;
  logic signed [CNT_W-1:0] ent_cnt;
  logic [VTX_W-1:0] ent_hi;
  logic [MAG_W-1:0] mag;
  logic [COPY_W-1:0] copies;
  logic exh_hit, emit_any, ev_go, hit;
  logic signed [CNT_W:0] sum;
  logic [CNT_W-1:0] sat;
  logic [VTX_W-1:0] ns, ne;
  result_t new_res;
  logic res_load;
  result_t res_data;

  assign accept = item_valid && !item_stall;
  assign item_stall = (state != S_IDLE);
  assign out_free = !result_valid || !result_stall;
  assign edge_addr = {lo, k[K_W-1:0]};

  // entry decode
  assign ent_hi = edge_rdata[ENT_W-1:CNT_W];
  assign ent_cnt = edge_rdata[CNT_W-1:0];
  assign hit = (ent_hi == hi);
  assign mag = ent_cnt[CNT_W-1] ? MAG_W'(-$signed({ent_cnt[CNT_W-1], ent_cnt}))
                                : MAG_W'({1'b0, ent_cnt});
  assign exh_hit = {{(AVAIL_W-MAG_W){1'b0}}, mag} > avail;
  assign copies = exh_hit ? COPY_W'(avail) : COPY_W'(mag);
  assign emit_any = (ent_cnt != '0) && (copies != '0);
  assign ev_go = !emit_any || !pend_valid || out_free;

  // saturating count update
  assign sum = $signed({ent_cnt[CNT_W-1], ent_cnt}) + (neg_dir ? -(CNT_W+1)'(1) : (CNT_W+1)'(1));
  always_comb begin
    if (sum > $signed((CNT_W+1)'((1 << (CNT_W-1)) - 1))) begin
      sat = CNT_W'((1 << (CNT_W-1)) - 1);
    end else if (sum < -$signed((CNT_W+1)'(1 << (CNT_W-1)))) begin
      sat = CNT_W'(1 << (CNT_W-1));
    end else begin
      sat = sum[CNT_W-1:0];
    end
  end

  // oriented result for the current entry
  assign ns = ent_cnt[CNT_W-1] ? ent_hi : lo;
  assign ne = ent_cnt[CNT_W-1] ? lo : ent_hi;
  always_comb begin
    new_res = '0;
    new_res.valid_res = 1'b1;
    new_res.near_start = ns;
    new_res.near_end = ne;
    new_res.far_start = FAR_W'({1'b0, ns}) + vertex_count;
    new_res.far_end = FAR_W'({1'b0, ne}) + vertex_count;
    new_res.copies = copies;
  end

  // next output register load
  always_comb begin
    res_load = 1'b0;
    res_data = '0;
    unique case (state)
      S_MARK: begin
        res_load = out_free;
        res_data.last = 1'b1;
      end
      E_EV: begin
        res_load = ev_go && emit_any && pend_valid;
        res_data = pend;
      end
      E_FIN: begin
        res_load = out_free;
        if (pend_valid) begin
          res_data = pend;
        end
        res_data.exhausted = budget_exhausted;
        res_data.last = 1'b1;
      end
      default: ;
    endcase
  end

  // memory and budget control
  always_comb begin
    len_we = 1'b0;
    len_waddr = lo;
    len_wdata = '0;
    len_re = 1'b0;
    edge_we = 1'b0;
    edge_wdata = {hi, sat};
    edge_re = 1'b0;
    bcmd = '0;
    unique case (state)
      S_INIT: begin
        len_we = 1'b1;
        len_waddr = init_ptr;
      end
      S_IDLE: begin
        if (accept && item.op == OP_CLEAR) begin
          len_we = 1'b1;
          len_waddr = item.vertex_a;
        end
        if (accept && item.op == OP_START) begin
          bcmd.restart = 1'b1;
        end
      end
      A_LEN: len_re = 1'b1;
      E_LEN: begin
        len_re = 1'b1;
        bcmd.load_prod = 1'b1;
      end
      E_LENW: bcmd.load_avail = 1'b1;
      A_RD: begin
        if (k == n) begin
          if (n < LEN_W'(EPV)) begin
            edge_we = 1'b1;
            edge_wdata = {hi, neg_dir ? {CNT_W{1'b1}} : CNT_W'(1)};
            len_we = 1'b1;
            len_wdata = n + LEN_W'(1);
          end
        end else begin
          edge_re = 1'b1;
        end
      end
      A_EV: edge_we = hit;
      E_RD: edge_re = (k != n);
      E_EV: begin
        if (ev_go && emit_any) begin
          bcmd.charge = 1'b1;
          bcmd.copies = copies;
        end
      end
      S_MARK, A_LENW, E_FIN: ;
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      index_capacity <= CAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_VCOUNT: vertex_count <= FAR_W'(cfg_data);
        CFG_CAP: index_capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      init_ptr <= '0;
      pend_valid <= 1'b0;
      budget_exhausted <= 1'b0;
    end else begin
      unique case (state)
        S_INIT: begin
          init_ptr <= init_ptr + VTX_W'(1);
          if (init_ptr == VTX_W'(NVTX - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            unique case (op_t'(item.op))
              OP_ADD: begin
                lo <= (item.vertex_a < item.vertex_b) ? item.vertex_a : item.vertex_b;
                hi <= (item.vertex_a < item.vertex_b) ? item.vertex_b : item.vertex_a;
                neg_dir <= (item.vertex_a > item.vertex_b);
                if (item.vertex_a != item.vertex_b) begin
                  state <= A_LEN;
                end
              end
              OP_CLEAR: ;
              OP_START: begin
                budget_exhausted <= 1'b0;
                state <= S_MARK;
              end
              OP_EMIT: begin
                lo <= item.vertex_a;
                state <= budget_exhausted ? E_FIN : E_LEN;
              end
              default: ;
            endcase
          end
        end
        S_MARK: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        A_LEN: state <= A_LENW;
        E_LEN: state <= E_LENW;
        A_LENW, E_LENW: begin
          n <= len_rdata;
          k <= '0;
          state <= (state == A_LENW) ? A_RD : E_RD;
        end
        A_RD: state <= (k == n) ? S_IDLE : A_EV;
        A_EV: begin
          k <= k + LEN_W'(1);
          state <= hit ? S_IDLE : A_RD;
        end
        E_RD: state <= (k == n) ? E_FIN : E_EV;
        E_EV: begin
          if (ev_go) begin
            if (emit_any) begin
              pend <= new_res;
              pend_valid <= 1'b1;
            end
            if (ent_cnt != '0 && exh_hit) begin
              budget_exhausted <= 1'b1;
              state <= E_FIN;
            end else begin
              k <= k + LEN_W'(1);
              state <= E_RD;
            end
          end
        end
        E_FIN: begin
          if (out_free) begin
            pend_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  seau_ram #(.WIDTH(LEN_W), .DEPTH(NVTX)) u_len_ram (
    .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
    .re(len_re), .raddr(lo), .rdata(len_rdata)
  );

  seau_ram #(.WIDTH(ENT_W), .DEPTH(NVTX * EPV)) u_edge_ram (
    .clk(clk), .we(edge_we), .waddr(edge_addr), .wdata(edge_wdata),
    .re(edge_re), .raddr(edge_addr), .rdata(edge_rdata)
  );

  seau_budget u_budget (
    .clk(clk), .rst(rst), .cap(index_capacity), .cmd(bcmd), .avail(avail)
  );

  // no transaction is taken during the length clearing pass
  a_init_stall: assert property (@(posedge clk) disable iff (rst)
    state == S_INIT |-> item_stall) else $error("item taken during clear pass");

  // a pending edge exists only inside an emit walk
  a_pend_scope: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == E_RD || state == E_EV || state == E_FIN))
    else $error("pending edge outside emit walk");

  // an edge result always carries at least one copy
  a_copies: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.valid_res |-> result.copies != '0)
    else $error("edge result with no copies");

  // a marker result always closes its transaction
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.valid_res |-> result.last)
    else $error("marker result without last");

endmodule

// ----- sim/silhouette_edge_accumulator_unit_tb.sv -----
// testbench for the silhouette edge accumulator: random and directed edge lists, emission check
`timescale 1ns / 1ps

module silhouette_edge_accumulator_unit_tb;
  import seau_pkg::*;

  localparam int STALL_PCT  = 23;
  localparam int HOLD_LEN   = 300;
  localparam int DRAIN_WAIT = 90;
  localparam int WD_LIMIT   = 6000;

  logic          clk;
  logic          rst;
  logic          item_valid;
  logic          item_stall;
  item_t         item;
  logic          result_valid;
  logic          result_stall;
  result_t       result;
  logic          cfg_we;
  logic          cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bit quiet;      // no idling on either side
  bit hold_req;   // receiver holds off for a long stretch

  // shadow of the edge lists with quad emission and budget
  class silhouette_scoreboard;
    int unsigned hi_vtx [NVTX][EPV];
    int          net_cnt[NVTX][EPV];
    int unsigned list_len[NVTX];
    int unsigned idx_used;
    bit          spent;
    int unsigned vcount;
    int unsigned cap;
    result_t     pending_q[$];
    int          errors;

    function void restart();
      foreach (list_len[v]) list_len[v] = 0;
      idx_used = 0;
      spent    = 0;
      vcount   = 0;
      cap      = 8192;
      errors   = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, int unsigned val);
      if (idx == CFG_VCOUNT) vcount = val & 11'h7FF;
      else cap = val & 14'h3FFF;
    endfunction

    function result_t quad(bit vld, int unsigned ns, int unsigned ne, int unsigned cp, bit lst);
      result_t r;
      r.valid_res  = vld;
      r.near_start = ns[VTX_W-1:0];
      r.near_end   = ne[VTX_W-1:0];
      r.far_start  = vld ? FAR_W'(ns + vcount) : '0;
      r.far_end    = vld ? FAR_W'(ne + vcount) : '0;
      r.copies     = cp[COPY_W-1:0];
      r.exhausted  = spent;
      r.last       = lst;
      return r;
    endfunction

    function void add_edge(int unsigned a, int unsigned b);
      int unsigned lo, hi, n;
      int dir, c;
      if (a == b) return;
      if (a < b) begin lo = a; hi = b; dir = 1; end
      else begin lo = b; hi = a; dir = -1; end
      n = list_len[lo];
      for (int k = 0; k < n; k++) begin
        if (hi_vtx[lo][k] == hi) begin
          c = net_cnt[lo][k] + dir;
          if (c > 127) c = 127;
          if (c < -128) c = -128;
          net_cnt[lo][k] = c;
          return;
        end
      end
      if (n < EPV) begin
        hi_vtx[lo][n]  = hi;
        net_cnt[lo][n] = dir;
        list_len[lo]   = n + 1;
      end
    endfunction

    function void emit_list(int unsigned a);
      result_t outs[$];
      int unsigned ia, ib, mag, cp;
      int net;
      if (!spent) begin
        for (int k = 0; k < list_len[a]; k++) begin
          net = net_cnt[a][k];
          if (net == 0) continue;
          if (net > 0) begin ia = a; ib = hi_vtx[a][k]; mag = net; end
          else begin ia = hi_vtx[a][k]; ib = a; mag = -net; end
          cp = 0;
          while (cp < mag) begin
            if (idx_used + QUAD > cap) begin
              spent = 1;
              break;
            end
            idx_used += QUAD;
            cp++;
          end
          if (cp > 0) outs.push_back(quad(1, ia, ib, cp, 0));
          if (spent) break;
        end
      end
      if (outs.size() == 0) outs.push_back(quad(0, 0, 0, 0, 1));
      else begin
        outs[$].exhausted = spent;
        outs[$].last      = 1;
      end
      foreach (outs[i]) pending_q.push_back(outs[i]);
    endfunction

    // an input transaction was accepted
    function void note_item(item_t it);
      case (op_t'(it.op))
        OP_ADD:   add_edge(it.vertex_a, it.vertex_b);
        OP_CLEAR: list_len[it.vertex_a] = 0;
        OP_START: begin
          idx_used = 0;
          spent    = 0;
          pending_q.push_back(quad(0, 0, 0, 0, 1));
        end
        default:  emit_list(it.vertex_a);
      endcase
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      errors++;
      $display("%0t: mismatch %s got %0d want %0d", $realtime, what, got, want);
    endtask

    // a result transaction was accepted
    task check(result_t r);
      result_t e;
      if (pending_q.size() == 0) begin
        report("unexpected result, valid_res", r.valid_res, 0);
        return;
      end
      e = pending_q.pop_front();
      if (r.valid_res !== e.valid_res) report("valid_res", r.valid_res, e.valid_res);
      if (r.near_start !== e.near_start) report("near_start", r.near_start, e.near_start);
      if (r.near_end !== e.near_end) report("near_end", r.near_end, e.near_end);
      if (r.far_start !== e.far_start) report("far_start", r.far_start, e.far_start);
      if (r.far_end !== e.far_end) report("far_end", r.far_end, e.far_end);
      if (r.copies !== e.copies) report("copies", r.copies, e.copies);
      if (r.exhausted !== e.exhausted) report("exhausted", r.exhausted, e.exhausted);
      if (r.last !== e.last) report("last", r.last, e.last);
    endtask
  endclass

  silhouette_scoreboard board;

  silhouette_edge_accumulator_unit DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // send one transaction, with random idle cycles ahead of it unless quiet is set
  task automatic send_item(op_t op, int unsigned a, int unsigned b);
    item_t it;
    it.op       = op;
    it.vertex_a = a[VTX_W-1:0];
    it.vertex_b = b[VTX_W-1:0];
    if (!quiet) begin
      while ($urandom_range(99) < STALL_PCT) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    board.note_item(it);
  endtask

  // wait until every expected result is in and the block has settled
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    @(posedge clk);
    board.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // well-formed burst on eight vertices at the low or the high end, with some noise
  task automatic edge_burst(int unsigned n_items);
    int unsigned base, a, b, pick;
    base = $urandom_range(0, 1);
    base = base ? 1016 : 0;
    send_item(OP_START, $urandom_range(0, 1023), $urandom_range(0, 1023));
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      a = base + $urandom_range(0, 7);
      b = base + $urandom_range(0, 7);
      if (pick < 60) send_item(OP_ADD, a, b);
      else if (pick < 80) send_item(OP_EMIT, a, $urandom_range(0, 1023));
      else if (pick < 85) send_item(OP_CLEAR, a, $urandom_range(0, 1023));
      else if (pick < 90) send_item(OP_START, a, b);
      else send_item(op_t'($urandom_range(0, 3)), $urandom_range(0, 1023),
                     $urandom_range(0, 1023));
    end
  endtask

  // receiver with random stalls and a long hold-off on request
  initial begin
    result_stall = 1'b1;
    @(posedge clk);
    forever begin
      if (result_valid && !result_stall) board.check(result);
      if (hold_req) begin
        result_stall <= 1'b1;
        for (int i = 0; i < HOLD_LEN; i++) begin
          @(posedge clk);
          if (result_valid && !result_stall) board.check(result);
        end
        hold_req = 0;
      end
      result_stall <= !quiet && ($urandom_range(99) < STALL_PCT);
      @(posedge clk);
    end
  end

  // watchdog on cycles with no transaction
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    board = new();
    board.restart();
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_VCOUNT;
    cfg_data   = '0;
    quiet      = 0;
    hold_req   = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: orientation, degenerate, extremes, clear, empty and start
    write_reg(CFG_VCOUNT, 1024);
    write_reg(CFG_CAP, 8192);
    send_item(OP_ADD, 3, 7);
    send_item(OP_ADD, 7, 3);
    send_item(OP_ADD, 7, 3);
    send_item(OP_ADD, 5, 5);
    send_item(OP_ADD, 1023, 1023);
    send_item(OP_ADD, 0, 1023);
    send_item(OP_ADD, 1023, 1022);
    send_item(OP_ADD, 1023, 1022);
    send_item(OP_EMIT, 3, 0);
    send_item(OP_EMIT, 0, 1023);
    send_item(OP_EMIT, 1022, 0);
    send_item(OP_EMIT, 1023, 1023);
    send_item(OP_EMIT, 5, 0);
    send_item(OP_START, 1023, 1023);
    send_item(OP_CLEAR, 0, 1023);
    send_item(OP_EMIT, 0, 0);
    send_item(OP_ADD, 3, 7);
    send_item(OP_EMIT, 3, 1023);
    send_item(OP_CLEAR, 1023, 0);
    send_item(OP_START, 0, 0);
    drain();

    // tiny budget: one copy then exhausted
    write_reg(CFG_CAP, 6);
    write_reg(CFG_VCOUNT, 0);
    send_item(OP_START, 0, 0);
    send_item(OP_ADD, 1, 2);
    send_item(OP_ADD, 1, 2);
    send_item(OP_ADD, 1, 3);
    send_item(OP_EMIT, 1, 0);
    send_item(OP_EMIT, 1, 0);
    send_item(OP_START, 0, 0);
    send_item(OP_EMIT, 1, 0);
    drain();

    // full list with no idling: the edge past the 32nd is dropped
    write_reg(CFG_CAP, 8192);
    write_reg(CFG_VCOUNT, 777);
    quiet = 1;
    send_item(OP_START, 0, 0);
    send_item(OP_CLEAR, 9, 0);
    for (int i = 0; i < 32; i++) send_item(OP_ADD, (i % 2) ? 9 : 10 + i, (i % 2) ? 10 + i : 9);
    send_item(OP_ADD, 9, 45);
    send_item(OP_EMIT, 9, 0);
    quiet = 0;
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_VCOUNT, 0); write_reg(CFG_CAP, 8192); end
        1: begin write_reg(CFG_VCOUNT, 1024); write_reg(CFG_CAP, 6); end
        default: begin
          write_reg(CFG_VCOUNT, $urandom_range(0, 1024));
          write_reg(CFG_CAP, $urandom_range(6, 300));
        end
      endcase
      if (ph == 3) begin
        // receiver holds off while emits pile up at the input
        hold_req = 1;
        for (int i = 0; i < 8; i++) send_item(OP_EMIT, $urandom_range(0, 7), 0);
      end
      edge_burst(4);
      drain();
    end

    item_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (board.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
